FILE: sv/lr35902_subset_cpu_core_macros.svh
// Assertion helpers shared by the core.
`ifndef LR35902_SUBSET_CPU_CORE_MACROS_SVH
`define LR35902_SUBSET_CPU_CORE_MACROS_SVH
`define LRC_ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define LRC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

FILE: sv/lrc_pkg.sv
package lrc_pkg;
  localparam int ADDR_BITS_DEF = 16;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_EXEC = 2'd3;
  localparam logic [2:0] ADDR_RESTART_PC = 3'd0;
  localparam logic [2:0] ADDR_RESTART_SP = 3'd4;
  localparam logic [15:0] RESTART_PC_RST = 16'h0100;
  localparam logic [15:0] RESTART_SP_RST = 16'hFFFE;
  localparam logic [15:0] HIGH_PAGE = 16'hFF00;
endpackage

FILE: sv/lr35902_subset_cpu_core.sv
// LR35902 subset core with an internal byte memory on one synchronous port.
// A memory write or restart is posted from the idle state; a memory read posts
// from the read-return state; an executed instruction fetches its opcode, reads
// any operand and data bytes, does a second write if it needs one, and posts
// from the done state. A new item is taken only once the sequencer is idle again;
// a result held in the output register by a stall holds off input.
// Reset (rst, synchronous) loads PC 0x0100, SP 0xFFFE, clears A..L and IME.
module lr35902_subset_cpu_core
  import lrc_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] prog_counter,
  output logic [15:0] stack_pointer,
  output logic [7:0]  accumulator,
  output logic [3:0]  flag_bits,
  output logic [15:0] pair_bc,
  output logic [15:0] pair_de,
  output logic [15:0] pair_hl,
  output logic        irq_master_enable,
  output logic [2:0]  machine_cycles,
  output logic [7:0]  read_byte,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
`include "lr35902_subset_cpu_core_macros.svh"

  // Sequencer states. Each memory read is issued in one state and its data
  // is used in the following state.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd2;  // opcode returned
  localparam logic [3:0] S_B1    = 4'd3;  // first operand byte returned
  localparam logic [3:0] S_B2    = 4'd4;  // second operand byte returned
  localparam logic [3:0] S_MR    = 4'd5;  // data read returned
  localparam logic [3:0] S_P1    = 4'd6;  // pop low returned
  localparam logic [3:0] S_P2    = 4'd7;  // pop high returned
  localparam logic [3:0] S_W2    = 4'd8;  // second write (push low / sp high)
  localparam logic [3:0] S_DONE  = 4'd9;  // post result
  localparam logic [3:0] S_RDW   = 4'd10; // command read returned

  logic [7:0] mem [0:(1<<ADDR_BITS)-1];
  logic       we;
  logic [15:0] maddr;
  logic [7:0] wdata, rdata;
  always_ff @(posedge clk) begin
    if (we) mem[maddr[ADDR_BITS-1:0]] <= wdata;
    rdata <= mem[maddr[ADDR_BITS-1:0]];
  end

  logic [15:0] restart_pc, restart_sp;
  logic [3:0] state, state_next;
  logic [15:0] pc, sp, pc_next, sp_next;
  logic [7:0] ra, ra_next, rb, rb_next, rc, rc_next, rd, rd_next;
  logic [7:0] re, re_next, rh, rh_next, rl, rl_next;
  logic [3:0] fl, fl_next;
  logic ime, ime_next;
  logic [7:0] op, op_next, lo, lo_next, hi, hi_next;
  logic [2:0] cyc, cyc_next;
  logic [7:0] rbyte, rbyte_next;
  logic [15:0] addr_q, addr_next;
  logic post;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'h0, restart_sp} : {16'h0, restart_pc};
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_pc <= RESTART_PC_RST;
      restart_sp <= RESTART_SP_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_RESTART_PC) restart_pc <= pwdata[15:0];
      else if (paddr == ADDR_RESTART_SP) restart_sp <= pwdata[15:0];
    end
  end

  // A new item waits while the sequencer is busy or while a finished result
  // sits stalled in the output register, so a posted result never
  // overwrites one that has not been taken.
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  logic acc;
  assign acc = in_valid && !in_stall;

  logic [15:0] hl;
  assign hl = {rh, rl};

  function automatic logic [7:0] get_r8(input logic [2:0] c, input logic [7:0] b,
      input logic [7:0] cc, input logic [7:0] d, input logic [7:0] e,
      input logic [7:0] h, input logic [7:0] l, input logic [7:0] a,
      input logic [7:0] m);
    case (c)
      3'd0: get_r8 = b;
      3'd1: get_r8 = cc;
      3'd2: get_r8 = d;
      3'd3: get_r8 = e;
      3'd4: get_r8 = h;
      3'd5: get_r8 = l;
      3'd6: get_r8 = m;
      default: get_r8 = a;
    endcase
  endfunction

  function automatic logic [3:0] cmp_flags(input logic [7:0] a, input logic [7:0] b);
    cmp_flags = {a == b, 1'b1, a[3:0] < b[3:0], a < b};
  endfunction

  // The condition code comes from the opcode on the read port while it is
  // being decoded, and from the opcode register in later states.
  logic [1:0] cc_sel;
  assign cc_sel = (state == S_DEC) ? rdata[4:3] : op[4:3];

  logic cond;
  always_comb begin
    case (cc_sel)
      2'd0: cond = !fl[3];
      2'd1: cond = fl[3];
      2'd2: cond = !fl[0];
      default: cond = fl[0];
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (post) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (post) begin
      prog_counter <= pc_next; stack_pointer <= sp_next; accumulator <= ra_next;
      flag_bits <= fl_next; pair_bc <= {rb_next, rc_next};
      pair_de <= {rd_next, re_next}; pair_hl <= {rh_next, rl_next};
      irq_master_enable <= ime_next; machine_cycles <= cyc_next;
      read_byte <= rbyte_next;
    end
  end

  logic [15:0] rel;
  logic [15:0] a16;
  logic [8:0] sum8;
  logic [4:0] sum4;
  logic [7:0] srcv;
  assign a16 = {rdata, lo};
  assign rel = pc + {{8{rdata[7]}}, rdata};
  assign sum8 = {1'b0, sp[7:0]} + {1'b0, rdata};
  assign sum4 = {1'b0, sp[3:0]} + {1'b0, rdata[3:0]};
  assign srcv = get_r8(op[2:0], rb, rc, rd, re, rh, rl, ra, rdata);

  always_comb begin
    state_next = state;
    pc_next = pc; sp_next = sp; ra_next = ra; fl_next = fl;
    rb_next = rb; rc_next = rc; rd_next = rd; re_next = re;
    rh_next = rh; rl_next = rl; ime_next = ime;
    op_next = op; lo_next = lo; hi_next = hi; cyc_next = cyc;
    rbyte_next = rbyte; addr_next = addr_q;
    we = 1'b0; maddr = addr_q; wdata = 8'h0; post = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          cyc_next = 3'd0; rbyte_next = 8'h0; addr_next = mem_address;
          case (command)
            CMD_WRITE: begin
              we = 1'b1; maddr = mem_address; wdata = mem_data; post = 1'b1;
            end
            CMD_READ: begin
              maddr = mem_address; state_next = S_RDW;
            end
            CMD_RESTART: begin
              pc_next = restart_pc; sp_next = restart_sp; ra_next = 8'h0;
              fl_next = 4'h0; rb_next = 8'h0; rc_next = 8'h0; rd_next = 8'h0;
              re_next = 8'h0; rh_next = 8'h0; rl_next = 8'h0; ime_next = 1'b0;
              post = 1'b1;
            end
            default: begin
              maddr = pc; pc_next = pc + 16'd1; state_next = S_DEC;
            end
          endcase
        end
      end
      S_RDW: begin
        rbyte_next = rdata; post = 1'b1; state_next = S_IDLE;
      end
      S_DEC: begin
        op_next = rdata; state_next = S_DONE; cyc_next = 3'd1;
        if (rdata >= 8'h40 && rdata <= 8'h7F && rdata != 8'h76) begin
          if (rdata[2:0] == 3'd6) begin
            maddr = hl; state_next = S_MR; cyc_next = 3'd2;
          end else if (rdata[5:3] == 3'd6) begin
            we = 1'b1; maddr = hl; cyc_next = 3'd2;
            wdata = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
          end else begin
            case (rdata[5:3])
              3'd0: rb_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              3'd1: rc_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              3'd2: rd_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              3'd3: re_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              3'd4: rh_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              3'd5: rl_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
              default: ra_next = get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0);
            endcase
          end
        end else if (rdata >= 8'hB8 && rdata <= 8'hBF) begin
          if (rdata[2:0] == 3'd6) begin
            maddr = hl; state_next = S_MR; cyc_next = 3'd2;
          end else begin
            fl_next = cmp_flags(ra, get_r8(rdata[2:0], rb, rc, rd, re, rh, rl, ra, 8'h0));
          end
        end else if (rdata <= 8'h3F && rdata[2:0] == 3'd6) begin
          maddr = pc; pc_next = pc + 16'd1; state_next = S_B1;
          cyc_next = (rdata[5:3] == 3'd6) ? 3'd3 : 3'd2;
        end else if (rdata >= 8'hC0 && rdata[2:0] == 3'd7) begin
          // RST: push PC high now, then push low and jump in S_W2.
          we = 1'b1; maddr = sp - 16'd1; wdata = pc[15:8];
          hi_next = 8'h0; lo_next = {2'b00, rdata[5:3], 3'b000};
          state_next = S_W2; cyc_next = 3'd4;
        end else begin
          case (rdata)
            8'h01, 8'h11, 8'h21, 8'h31, 8'h08, 8'h18, 8'h20, 8'h28, 8'h30,
            8'h38, 8'hC2, 8'hCA, 8'hD2, 8'hDA, 8'hC3, 8'hC4, 8'hCC, 8'hD4,
            8'hDC, 8'hCD, 8'hE0, 8'hF0, 8'hEA, 8'hFA, 8'hF8, 8'hFE: begin
              maddr = pc; pc_next = pc + 16'd1; state_next = S_B1;
            end
            8'h02: begin we = 1'b1; maddr = {rb, rc}; wdata = ra; cyc_next = 3'd2; end
            8'h12: begin we = 1'b1; maddr = {rd, re}; wdata = ra; cyc_next = 3'd2; end
            8'h0A: begin maddr = {rb, rc}; state_next = S_MR; cyc_next = 3'd2; end
            8'h1A: begin maddr = {rd, re}; state_next = S_MR; cyc_next = 3'd2; end
            8'h22, 8'h32: begin
              we = 1'b1; maddr = hl; wdata = ra; cyc_next = 3'd2;
              {rh_next, rl_next} = rdata[4] ? hl - 16'd1 : hl + 16'd1;
            end
            8'h2A, 8'h3A: begin maddr = hl; state_next = S_MR; cyc_next = 3'd2; end
            8'hE2: begin
              we = 1'b1; maddr = HIGH_PAGE | {8'h0, rc}; wdata = ra; cyc_next = 3'd2;
            end
            8'hF2: begin
              maddr = HIGH_PAGE | {8'h0, rc}; state_next = S_MR; cyc_next = 3'd2;
            end
            8'hE9: pc_next = hl;
            8'hF9: begin sp_next = hl; cyc_next = 3'd2; end
            8'hC0, 8'hC8, 8'hD0, 8'hD8: begin
              cyc_next = 3'd2;
              if (cond) begin maddr = sp; state_next = S_P1; cyc_next = 3'd5; end
            end
            8'hC9, 8'hD9: begin maddr = sp; state_next = S_P1; cyc_next = 3'd4; end
            8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
              maddr = sp; state_next = S_P1; cyc_next = 3'd3;
            end
            8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
              we = 1'b1; maddr = sp - 16'd1; cyc_next = 3'd4; state_next = S_W2;
              case (rdata[5:4])
                2'd0: begin wdata = rb; lo_next = rc; end
                2'd1: begin wdata = rd; lo_next = re; end
                2'd2: begin wdata = rh; lo_next = rl; end
                default: begin wdata = ra; lo_next = {fl, 4'h0}; end
              endcase
            end
            default: ;
          endcase
        end
      end
      S_B1: begin
        state_next = S_DONE; lo_next = rdata;
        if (op <= 8'h3F && op[2:0] == 3'd6) begin
          if (op[5:3] == 3'd6) begin we = 1'b1; maddr = hl; wdata = rdata; end
          else begin
            case (op[5:3])
              3'd0: rb_next = rdata;
              3'd1: rc_next = rdata;
              3'd2: rd_next = rdata;
              3'd3: re_next = rdata;
              3'd4: rh_next = rdata;
              3'd5: rl_next = rdata;
              default: ra_next = rdata;
            endcase
          end
        end else begin
          case (op)
            8'h18: begin pc_next = rel; cyc_next = 3'd3; end
            8'h20, 8'h28, 8'h30, 8'h38: begin
              cyc_next = 3'd2;
              if (cond) begin pc_next = rel; cyc_next = 3'd3; end
            end
            8'hE0: begin
              we = 1'b1; maddr = HIGH_PAGE | {8'h0, rdata}; wdata = ra; cyc_next = 3'd3;
            end
            8'hF0: begin
              maddr = HIGH_PAGE | {8'h0, rdata}; state_next = S_MR; cyc_next = 3'd3;
            end
            8'hF8: begin
              fl_next = {2'b00, sum4[4], sum8[8]};
              {rh_next, rl_next} = sp + {{8{rdata[7]}}, rdata}; cyc_next = 3'd3;
            end
            8'hFE: begin fl_next = cmp_flags(ra, rdata); cyc_next = 3'd2; end
            default: begin maddr = pc; pc_next = pc + 16'd1; state_next = S_B2; end
          endcase
        end
      end
      S_B2: begin
        state_next = S_DONE;
        case (op)
          8'h01: begin rb_next = rdata; rc_next = lo; cyc_next = 3'd3; end
          8'h11: begin rd_next = rdata; re_next = lo; cyc_next = 3'd3; end
          8'h21: begin rh_next = rdata; rl_next = lo; cyc_next = 3'd3; end
          8'h31: begin sp_next = a16; cyc_next = 3'd3; end
          8'h08: begin
            we = 1'b1; maddr = a16; wdata = sp[7:0]; cyc_next = 3'd5;
            addr_next = a16 + 16'd1; hi_next = sp[15:8]; state_next = S_W2;
          end
          8'hC2, 8'hCA, 8'hD2, 8'hDA: begin
            cyc_next = 3'd3;
            if (cond) begin pc_next = a16; cyc_next = 3'd4; end
          end
          8'hC3: begin pc_next = a16; cyc_next = 3'd4; end
          8'hC4, 8'hCC, 8'hD4, 8'hDC, 8'hCD: begin
            cyc_next = 3'd3;
            if (cond || op == 8'hCD) begin
              we = 1'b1; maddr = sp - 16'd1; wdata = pc[15:8]; cyc_next = 3'd6;
              lo_next = rdata; hi_next = lo; state_next = S_W2;
            end
          end
          8'hEA: begin we = 1'b1; maddr = a16; wdata = ra; cyc_next = 3'd4; end
          8'hFA: begin maddr = a16; state_next = S_MR; cyc_next = 3'd4; end
          default: ;
        endcase
      end
      S_W2: begin
        state_next = S_DONE; we = 1'b1;
        if (op == 8'h08) begin maddr = addr_q; wdata = hi; end
        else begin
          maddr = sp - 16'd2; sp_next = sp - 16'd2;
          if (op[3:0] == 4'h5) wdata = lo;
          else begin
            wdata = pc[7:0];
            // lo/hi hold target: RST {hi=0,lo=vec}; CALL {lo=high,hi=low}.
            pc_next = (op[2:0] == 3'd7) ? {8'h0, lo} : {lo, hi};
          end
        end
      end
      S_MR: begin
        state_next = S_DONE;
        if (op >= 8'h40 && op <= 8'h7F) begin
          case (op[5:3])
            3'd0: rb_next = rdata;
            3'd1: rc_next = rdata;
            3'd2: rd_next = rdata;
            3'd3: re_next = rdata;
            3'd4: rh_next = rdata;
            3'd5: rl_next = rdata;
            default: ra_next = rdata;
          endcase
        end else if (op >= 8'hB8 && op <= 8'hBF) begin
          fl_next = cmp_flags(ra, srcv);
        end else begin
          ra_next = rdata;
          if (op == 8'h2A) {rh_next, rl_next} = hl + 16'd1;
          if (op == 8'h3A) {rh_next, rl_next} = hl - 16'd1;
        end
      end
      S_P1: begin
        lo_next = rdata; maddr = sp + 16'd1; state_next = S_P2;
      end
      S_P2: begin
        state_next = S_DONE; sp_next = sp + 16'd2;
        case (op)
          8'hC1: begin rb_next = rdata; rc_next = lo; end
          8'hD1: begin rd_next = rdata; re_next = lo; end
          8'hE1: begin rh_next = rdata; rl_next = lo; end
          8'hF1: begin ra_next = rdata; fl_next = lo[7:4]; end
          8'hD9: begin pc_next = a16; ime_next = 1'b1; end
          default: pc_next = a16;
        endcase
      end
      S_DONE: begin
        post = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= RESTART_PC_RST; sp <= RESTART_SP_RST; ra <= 8'h0; fl <= 4'h0;
      rb <= 8'h0; rc <= 8'h0; rd <= 8'h0; re <= 8'h0; rh <= 8'h0; rl <= 8'h0;
      ime <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next; sp <= sp_next; ra <= ra_next; fl <= fl_next;
      rb <= rb_next; rc <= rc_next; rd <= rd_next; re <= re_next;
      rh <= rh_next; rl <= rl_next; ime <= ime_next;
    end
  end
  always_ff @(posedge clk) begin
    op <= op_next; lo <= lo_next; hi <= hi_next; cyc <= cyc_next;
    rbyte <= rbyte_next; addr_q <= addr_next;
  end

  `LRC_ASSERT_NEXT(a_busy_after_exec, acc && command == CMD_EXEC, in_stall)
  `LRC_ASSERT_NEXT(a_post_valid, post, out_valid)
  `LRC_ASSERT_IMPL(a_no_post_busy, post && state != S_IDLE, state_next == S_IDLE)
endmodule
